@@ hw/rtl/culw_pkg.sv @@
// shared types and constants for the unstable log window
`timescale 1ns / 1ps

package culw_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [2:0] ACT_APPEND      = 3'd0;
  localparam logic [2:0] ACT_STABLE_TO   = 3'd1;
  localparam logic [2:0] ACT_STABLE_SNAP = 3'd2;
  localparam logic [2:0] ACT_RESTORE     = 3'd3;
  localparam logic [2:0] ACT_QUERY       = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_GAP  = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] index;
    logic [63:0] entry_term;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [63:0] found_term;
    logic        first_valid;
    logic [63:0] first_index;
    logic        last_valid;
    logic [63:0] last_index;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

@@ hw/rtl/culw_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module culw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/consensus_unstable_log_window.sv @@
// top level: unstable log window with ring term store and pending snapshot
`timescale 1ns / 1ps

// an item's store read completes at its transfer edge, and execute then registers its result
//   into the output register, held back while a waiting result is stalled by out_stall
// a new item transfers only once the previous one has executed after its store read
// the output register lets the next item transfer while a result waits
// reset: synchronous active-low rst_n clears window, snapshot and handshake state;
//   the term store is not cleared, only read data from slots inside the window is ever used
module consensus_unstable_log_window
  import culw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // ring slot arithmetic: head plus an offset below DEPTH, wrapped once
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW + 1)'(DEPTH)) begin
      s = s - (AW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // control and window state
  state_t          state_r, state_nxt;
  logic [63:0]     base_r, base_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [63:0]     tail_r, tail_nxt;        // base + count - 1 while count != 0
  logic            snap_vld_r, snap_vld_nxt;
  logic [63:0]     snap_idx_r, snap_idx_nxt;
  logic [63:0]     snap_term_r, snap_term_nxt;
  logic [63:0]     snap_first_r, snap_first_nxt; // snap index plus one

  // item held between transfer and execute
  in_item_t        item_r;
  logic [CW-1:0]   dlo_r;
  logic            lt_base_r;
  logic            eq_base_r;
  logic            in_win_r;
  logic            at_tail_r;
  logic [AW-1:0]   slot_r;

  // output register
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // term store ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [63:0]     ram_rdata;

  // transfer-side decode
  logic            in_xfer;
  logic [63:0]     diff;
  logic            hi_zero;
  logic            lt_base;
  logic [AW-1:0]   rd_slot;

  logic            fire;
  logic [1:0]      status;
  logic            found;
  logic [63:0]     found_term;
  logic [63:0]     idx_inc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // offset from base, valid as a distance only when index is not below base
  assign diff    = in_data.index - base_r;
  assign hi_zero = (diff[63:CW] == '0);
  assign lt_base = (in_data.index < base_r);
  assign rd_slot = slot_add(head_r, diff[AW-1:0]);

  culw_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_term_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (item_r.entry_term),
    .rd_en   (in_xfer),
    .rd_addr (rd_slot),
    .rd_data (ram_rdata)
  );

  // execute completes once the output register is free or being drained
  assign fire    = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign idx_inc = item_r.index + 64'd1;

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    tail_nxt       = tail_r;
    snap_vld_nxt   = snap_vld_r;
    snap_idx_nxt   = snap_idx_r;
    snap_term_nxt  = snap_term_r;
    snap_first_nxt = snap_first_r;
    status         = ST_MISS;
    found          = 1'b0;
    found_term     = '0;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;

    case (item_r.action)
      ACT_APPEND: begin
        if (at_tail_r) begin
          // plain append after the last entry
          if (count_r == CW'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            tail_nxt  = item_r.index;
            status    = ST_OK;
          end
        end else if (lt_base_r || eq_base_r) begin
          // at or below base: window becomes this one entry
          ram_we    = 1'b1;
          ram_waddr = '0;
          base_nxt  = item_r.index;
          head_nxt  = '0;
          count_nxt = CW'(1);
          tail_nxt  = item_r.index;
          status    = ST_OK;
        end else if (in_win_r) begin
          // conflicting tail: truncate then append
          ram_we    = 1'b1;
          count_nxt = dlo_r + CW'(1);
          tail_nxt  = item_r.index;
          status    = ST_OK;
        end else begin
          status = ST_GAP;
        end
      end
      ACT_STABLE_TO: begin
        if (in_win_r && (ram_rdata == item_r.entry_term)) begin
          head_nxt  = slot_add(slot_r, AW'(1));
          count_nxt = count_r - dlo_r - CW'(1);
          base_nxt  = idx_inc;
          status    = ST_OK;
        end
      end
      ACT_STABLE_SNAP: begin
        if (snap_vld_r && (snap_idx_r == item_r.index)) begin
          snap_vld_nxt = 1'b0;
          status       = ST_OK;
        end
      end
      ACT_RESTORE: begin
        base_nxt       = idx_inc;
        head_nxt       = '0;
        count_nxt      = '0;
        snap_vld_nxt   = 1'b1;
        snap_idx_nxt   = item_r.index;
        snap_term_nxt  = item_r.entry_term;
        snap_first_nxt = idx_inc;
        status         = ST_OK;
      end
      ACT_QUERY: begin
        if (lt_base_r) begin
          if (snap_vld_r && (snap_idx_r == item_r.index)) begin
            found      = 1'b1;
            found_term = snap_term_r;
          end
        end else if (in_win_r) begin
          found      = 1'b1;
          found_term = ram_rdata;
        end
        status = found ? ST_OK : ST_MISS;
      end
      default: begin
        status = ST_MISS;
      end
    endcase

    // result seen after the action
    out_data_nxt.status      = status;
    out_data_nxt.found       = found;
    out_data_nxt.found_term  = found_term;
    out_data_nxt.first_valid = snap_vld_nxt;
    out_data_nxt.first_index = snap_vld_nxt ? snap_first_nxt : '0;
    if (count_nxt != '0) begin
      out_data_nxt.last_valid = 1'b1;
      out_data_nxt.last_index = tail_nxt;
    end else if (snap_vld_nxt) begin
      out_data_nxt.last_valid = 1'b1;
      out_data_nxt.last_index = snap_idx_nxt;
    end else begin
      out_data_nxt.last_valid = 1'b0;
      out_data_nxt.last_index = '0;
    end

    // nothing commits unless execute actually completes
    if (!fire) begin
      ram_we = 1'b0;
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = 1'b1;
      state_nxt     = S_IDLE;
    end else if (in_xfer) begin
      state_nxt = S_EXEC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= '0;
      head_r       <= '0;
      count_r      <= '0;
      tail_r       <= '0;
      snap_vld_r   <= 1'b0;
      snap_idx_r   <= '0;
      snap_term_r  <= '0;
      snap_first_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        base_r       <= base_nxt;
        head_r       <= head_nxt;
        count_r      <= count_nxt;
        tail_r       <= tail_nxt;
        snap_vld_r   <= snap_vld_nxt;
        snap_idx_r   <= snap_idx_nxt;
        snap_term_r  <= snap_term_nxt;
        snap_first_r <= snap_first_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r    <= in_data;
      dlo_r     <= diff[CW-1:0];
      lt_base_r <= lt_base;
      eq_base_r <= (diff == '0);
      in_win_r  <= !lt_base && hi_zero && (diff[CW-1:0] < count_r);
      at_tail_r <= !lt_base && hi_zero && (diff[CW-1:0] == count_r);
      slot_r    <= rd_slot;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // window never holds more entries than the store has slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds store depth");

  // a transferred item always moves to execute
  a_xfer_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_EXEC)
    else $error("transfer did not start execute");

  // a waiting result is never overwritten by a completing execute
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && out_valid_r && out_stall |=> state_r == S_EXEC)
    else $error("execute completed into a full output register");

  // an empty window and no snapshot report no last index
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (count_nxt == '0) && !snap_vld_nxt |=> !out_data_r.last_valid)
    else $error("last index reported with nothing pending");

endmodule
